// ===== rtl/flg_pkg.sv =====
package flg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SINE_W   = 17;
    localparam int PROD_W   = 33;
    localparam int CFG_W    = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd2;

    localparam logic [9:0]  MAX_DELAY_RST  = 10'd600;
    localparam logic [15:0] MIX_GAIN_RST   = 16'd26214;
    localparam logic [30:0] PHASE_STEP_RST = 31'd1947831;

    localparam logic [16:0] GAIN_ONE = 17'd32768;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef struct packed {
        logic we;
        logic re;
    } t_hist_ctl;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DELAY = 4'b0010,
        ST_MIX   = 4'b0100,
        ST_SUM   = 4'b1000
    } t_state;

    // Q15 sine, amplitude 32768, quarter wave symmetry and Q30 series
    function automatic int sine_q15(input int k_in, input int bits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        int          n;
        int          half;
        int          quarter;
        int          k;
        logic        neg;
        n       = 1 << bits;
        half    = n >> 1;
        quarter = n >> 2;
        k       = k_in & (n - 1);
        neg     = (k >= half);
        if (neg) begin
            k = k - half;
        end
        if (k > quarter) begin
            k = half - k;
        end
        x    = (64'(k) * TWO_PI_Q30) >> bits;
        sum  = x;
        term = x;
        for (int i = 1; i <= 7; i++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (i)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                default: term = term / 64'd210;
            endcase
            if ((i & 1) != 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
        if (v > 64'd32768) begin
            v = 64'd32768;
        end
        return neg ? -int'(v[16:0]) : int'(v[16:0]);
    endfunction

endpackage

// ===== rtl/flg_in_if.sv =====
interface flg_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [flg_pkg::SAMPLE_W-1:0] left_sample;
    logic signed [flg_pkg::SAMPLE_W-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ===== rtl/flg_out_if.sv =====
interface flg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [flg_pkg::SAMPLE_W-1:0] left_out;
    logic signed [flg_pkg::SAMPLE_W-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/flg_sine.sv =====
module flg_sine #(
    parameter int TABLE_BITS = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rd_en,
    input  logic [TABLE_BITS-1:0]              i_index,
    output logic signed [flg_pkg::SINE_W-1:0]  o_sine
);

    localparam int N = 1 << TABLE_BITS;

    logic signed [flg_pkg::SINE_W-1:0] w_rom [N];
    logic signed [flg_pkg::SINE_W-1:0] r_sine;

    for (genvar k = 0; k < N; k++) begin : g_rom
        assign w_rom[k] = flg_pkg::SINE_W'(flg_pkg::sine_q15(k, TABLE_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_sine <= w_rom[i_index];
        end
    end

    assign o_sine = r_sine;

endmodule

// ===== rtl/flg_hist.sv =====
module flg_hist #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                                i_clk,
    input  flg_pkg::t_hist_ctl                  i_ctl,
    input  logic [AW-1:0]                       i_waddr,
    input  logic [2*flg_pkg::SAMPLE_W-1:0]      i_wdata,
    input  logic [AW-1:0]                       i_raddr,
    output logic [2*flg_pkg::SAMPLE_W-1:0]      o_rdata
);

    logic [2*flg_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic [2*flg_pkg::SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/flg_mix.sv =====
module flg_mix (
    input  logic signed [flg_pkg::PROD_W-1:0]   i_prod_wet,
    input  logic signed [flg_pkg::PROD_W-1:0]   i_prod_dry,
    output logic signed [flg_pkg::SAMPLE_W-1:0] o_sample
);

    localparam int SUM_W = flg_pkg::PROD_W + 1;
    localparam int SH_W  = SUM_W - 15;

    logic signed [SUM_W-1:0] w_sum;
    logic signed [SH_W-1:0]  w_sh;

    assign w_sum = SUM_W'(i_prod_wet) + SUM_W'(i_prod_dry);
    assign w_sh  = w_sum[SUM_W-1:15];

    always_comb begin
        if (w_sh > SH_W'(32767)) begin
            o_sample = 16'sh7FFF;
        end else if (w_sh < -SH_W'(32768)) begin
            o_sample = 16'sh8000;
        end else begin
            o_sample = w_sh[flg_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

// ===== rtl/stereo_flanger.sv =====
// Stereo flanger with a sine sweep.
// Input channel i_in carries one stereo frame per word (left_sample, right_sample);
// output channel o_out carries one flanged frame per word (left_out, right_out).
// Both use valid/ready; a word moves when valid and ready are high at a clock edge.
// Registers max_delay, mix_gain, phase_step are set via i_cfg_we, i_cfg_index and
// i_cfg_data; the user must do so only while the block is idle: it is not enforced.
// The sine ROM is read at acceptance; the frame then passes the steps delay and
// history read, gain products with history write, and sum and saturate into the
// output register. The history memory and the gain multipliers are used once per
// frame, and i_in is ready only in idle: a new frame waits for the last to finish.
// The output register holds a finished frame while o_out is stalled; the next
// frame is accepted meanwhile and waits in its last step until the register frees.
// Reset loads the register defaults, zeros the sweep phase and write pointer and
// empties the history: a fill count makes unwritten history read as silence, so
// no clearing pass is needed and i_in is ready straight after reset.
module stereo_flanger #(
    parameter int HISTORY_DEPTH   = 2048,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    flg_in_if.sink                            i_in,
    flg_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [flg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [flg_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int DW = AW + 1;
    localparam int SW = flg_pkg::SAMPLE_W;
    localparam int PW = flg_pkg::PROD_W;

    flg_pkg::t_state r_state;

    logic [9:0]  r_max_delay;
    logic [15:0] r_mix_gain;
    logic [30:0] r_phase_step;

    logic [31:0]   r_phase;
    logic [AW-1:0] r_wp;
    logic [DW-1:0] r_fill;
    logic          r_zero_d;
    logic          r_use_hist;

    logic signed [SW-1:0] r_left;
    logic signed [SW-1:0] r_right;
    logic signed [PW-1:0] r_pw_l;
    logic signed [PW-1:0] r_pd_l;
    logic signed [PW-1:0] r_pw_r;
    logic signed [PW-1:0] r_pd_r;

    logic                 r_out_valid;
    logic signed [SW-1:0] r_left_out;
    logic signed [SW-1:0] r_right_out;

    logic                              w_accept;
    logic                              w_load_out;
    logic signed [flg_pkg::SINE_W-1:0] w_sine;
    logic [16:0]                       w_u;
    logic [26:0]                       w_dprod;
    logic [31:0]                       w_d32;
    logic [DW-1:0]                     w_dc;
    logic [DW-1:0]                     w_wp_ext;
    logic [DW-1:0]                     w_idx_ext;
    flg_pkg::t_hist_ctl                w_hist_ctl;
    logic [2*SW-1:0]                   w_rdata;
    logic [15:0]                       w_gain;
    logic signed [16:0]                w_gw;
    logic signed [16:0]                w_gd;
    logic signed [SW-1:0]              w_wet_l;
    logic signed [SW-1:0]              w_wet_r;
    logic signed [SW-1:0]              w_mix_l;
    logic signed [SW-1:0]              w_mix_r;

    assign i_in.ready      = (r_state == flg_pkg::ST_IDLE);
    assign w_accept        = i_in.valid && i_in.ready;
    assign w_load_out      = (r_state == flg_pkg::ST_SUM) && (!r_out_valid || o_out.ready);
    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_left_out;
    assign o_out.right_out = r_right_out;

    flg_sine #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .i_clk   (i_clk),
        .i_rd_en (w_accept),
        .i_index (r_phase[31 -: SINE_TABLE_BITS]),
        .o_sine  (w_sine)
    );

    assign w_u     = 17'(flg_pkg::GAIN_ONE + w_sine);
    assign w_dprod = 27'(r_max_delay) * 27'(w_u);
    assign w_d32   = 32'(w_dprod[26:15]);

    always_comb begin
        if (w_d32 > 32'(HISTORY_DEPTH)) begin
            w_dc = DW'(HISTORY_DEPTH);
        end else begin
            w_dc = w_d32[DW-1:0];
        end
    end

    assign w_wp_ext = {1'b0, r_wp};

    always_comb begin
        if (w_wp_ext >= w_dc) begin
            w_idx_ext = w_wp_ext - w_dc;
        end else begin
            w_idx_ext = w_wp_ext + DW'(HISTORY_DEPTH) - w_dc;
        end
    end

    assign w_hist_ctl.re = (r_state == flg_pkg::ST_DELAY);
    assign w_hist_ctl.we = (r_state == flg_pkg::ST_MIX);

    flg_hist #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_ctl   (w_hist_ctl),
        .i_waddr (r_wp),
        .i_wdata ({r_left, r_right}),
        .i_raddr (w_idx_ext[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_gain = ({1'b0, r_mix_gain} > flg_pkg::GAIN_ONE) ? flg_pkg::GAIN_ONE[15:0]
                                                             : r_mix_gain;
    assign w_gw   = $signed({1'b0, w_gain});
    assign w_gd   = $signed(flg_pkg::GAIN_ONE - {1'b0, w_gain});

    always_comb begin
        if (r_zero_d) begin
            w_wet_l = r_left;
            w_wet_r = r_right;
        end else if (r_use_hist) begin
            w_wet_l = w_rdata[2*SW-1:SW];
            w_wet_r = w_rdata[SW-1:0];
        end else begin
            w_wet_l = '0;
            w_wet_r = '0;
        end
    end

    flg_mix u_mix_l (
        .i_prod_wet (r_pw_l),
        .i_prod_dry (r_pd_l),
        .o_sample   (w_mix_l)
    );

    flg_mix u_mix_r (
        .i_prod_wet (r_pw_r),
        .i_prod_dry (r_pd_r),
        .o_sample   (w_mix_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_delay  <= flg_pkg::MAX_DELAY_RST;
            r_mix_gain   <= flg_pkg::MIX_GAIN_RST;
            r_phase_step <= flg_pkg::PHASE_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                flg_pkg::CFG_MAX_DELAY:  r_max_delay  <= i_cfg_data[9:0];
                flg_pkg::CFG_MIX_GAIN:   r_mix_gain   <= i_cfg_data[15:0];
                flg_pkg::CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= flg_pkg::ST_IDLE;
            r_phase     <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                flg_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_phase <= r_phase + {1'b0, r_phase_step};
                        r_state <= flg_pkg::ST_DELAY;
                    end
                end
                flg_pkg::ST_DELAY: begin
                    r_state <= flg_pkg::ST_MIX;
                end
                flg_pkg::ST_MIX: begin
                    r_wp <= (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                    if (r_fill != DW'(HISTORY_DEPTH)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= flg_pkg::ST_SUM;
                end
                flg_pkg::ST_SUM: begin
                    if (w_load_out) begin
                        r_state <= flg_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= flg_pkg::ST_IDLE;
                end
            endcase
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left  <= i_in.left_sample;
            r_right <= i_in.right_sample;
        end
        if (r_state == flg_pkg::ST_DELAY) begin
            r_zero_d   <= (w_dc == '0);
            r_use_hist <= (w_dc <= r_fill);
        end
        if (r_state == flg_pkg::ST_MIX) begin
            r_pw_l <= PW'(w_gw) * PW'(w_wet_l);
            r_pd_l <= PW'(w_gd) * PW'(r_left);
            r_pw_r <= PW'(w_gw) * PW'(w_wet_r);
            r_pd_r <= PW'(w_gd) * PW'(r_right);
        end
        if (w_load_out) begin
            r_left_out  <= w_mix_l;
            r_right_out <= w_mix_r;
        end
    end

endmodule

// ===== verif/flg_tb_pkg.sv =====
`timescale 1ns / 1ps

package flg_tb_pkg;

    import flg_pkg::*;

    localparam int          HIST_DEPTH  = 2048;
    localparam int          SINE_BITS   = 10;
    localparam int          UNITY_GAIN  = 32768;
    localparam logic [63:0] TWO_PI_FIX  = 64'd6746518852;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } t_stereo_frame;

    class flanger_checker;

        int                         errors;
        t_stereo_frame              expected_frames[$];

        logic [9:0]                 max_delay;
        logic [15:0]                mix_gain;
        logic [30:0]                phase_step;
        logic [31:0]                lfo_phase;
        logic [10:0]                wr_pos;
        logic signed [SAMPLE_W-1:0] left_hist [0:HIST_DEPTH-1];
        logic signed [SAMPLE_W-1:0] right_hist [0:HIST_DEPTH-1];
        int                         sine_q15 [0:(1<<SINE_BITS)-1];

        function new();
            errors     = 0;
            max_delay  = MAX_DELAY_RST;
            mix_gain   = MIX_GAIN_RST;
            phase_step = PHASE_STEP_RST;
            lfo_phase  = '0;
            wr_pos     = '0;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                left_hist[i]  = '0;
                right_hist[i] = '0;
            end
            for (int k = 0; k < (1 << SINE_BITS); k++) begin
                sine_q15[k] = calc_sine(k);
            end
        endfunction

        function int calc_sine(int k_in);
            logic [63:0] x;
            logic [63:0] term;
            logic [63:0] acc;
            logic [63:0] v;
            int          k;
            logic        neg;
            k   = k_in;
            neg = (k >= (1 << (SINE_BITS - 1)));
            if (neg) begin
                k = k - (1 << (SINE_BITS - 1));
            end
            if (k > (1 << (SINE_BITS - 2))) begin
                k = (1 << (SINE_BITS - 1)) - k;
            end
            x    = (64'(k) * TWO_PI_FIX) >> SINE_BITS;
            acc  = x;
            term = x;
            for (int j = 1; j <= 7; j++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * j) * (2 * j + 1));
                if (j % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            v = (acc * 64'd32768 + (64'd1 << 29)) >> 30;
            if (v > 64'd32768) begin
                v = 64'd32768;
            end
            return neg ? -int'(v) : int'(v);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_MAX_DELAY:  max_delay  = val[9:0];
                CFG_MIX_GAIN:   mix_gain   = val[15:0];
                CFG_PHASE_STEP: phase_step = val[30:0];
                default: ;
            endcase
        endfunction

        function logic signed [SAMPLE_W-1:0] blend(longint g, longint wet, longint dry);
            longint acc;
            acc = g * wet + (UNITY_GAIN - g) * dry;
            acc = acc >>> 15;
            if (acc < -32768) begin
                acc = -32768;
            end
            if (acc > 32767) begin
                acc = 32767;
            end
            return acc[SAMPLE_W-1:0];
        endfunction

        function void note_frame(t_stereo_frame din);
            int                         s;
            int unsigned                dly;
            longint                     g;
            logic [10:0]                rd;
            logic signed [SAMPLE_W-1:0] wet_l;
            logic signed [SAMPLE_W-1:0] wet_r;
            t_stereo_frame              want;
            s   = sine_q15[lfo_phase[31:32-SINE_BITS]];
            dly = (int'(max_delay) * (UNITY_GAIN + s)) >> 15;
            if (dly > HIST_DEPTH) begin
                dly = HIST_DEPTH;
            end
            g     = (mix_gain > UNITY_GAIN) ? UNITY_GAIN : longint'(mix_gain);
            wet_l = din.left;
            wet_r = din.right;
            if (dly != 0) begin
                rd    = wr_pos - 11'(dly);
                wet_l = left_hist[rd];
                wet_r = right_hist[rd];
            end
            want.left  = blend(g, wet_l, din.left);
            want.right = blend(g, wet_r, din.right);
            expected_frames.push_back(want);
            left_hist[wr_pos]  = din.left;
            right_hist[wr_pos] = din.right;
            wr_pos    = wr_pos + 11'd1;
            lfo_phase = lfo_phase + 32'(phase_step);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_frame(t_stereo_frame got);
            t_stereo_frame want;
            if (expected_frames.size() == 0) begin
                report("unexpected word, left", got.left, 0);
            end else begin
                want = expected_frames.pop_front();
                if (got.left !== want.left) begin
                    report("left_out", got.left, want.left);
                end
                if (got.right !== want.right) begin
                    report("right_out", got.right, want.right);
                end
            end
        endtask

        function int pending();
            return expected_frames.size();
        endfunction

    endclass

endpackage

// ===== verif/tb_stereo_flanger.sv =====
`timescale 1ns / 1ps

module tb_stereo_flanger;

    import flg_pkg::*;
    import flg_tb_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 200;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    flg_in_if  in_ch ();
    flg_out_if out_ch ();

    flanger_checker sb;
    bit             src_idle_on;
    bit             sink_idle_on;
    bit             hold_req;
    int             quiet_cycles;

    stereo_flanger u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            sb.check_frame('{left: out_ch.left_out, right: out_ch.right_out});
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_stereo_flanger failed");
                $finish;
            end
        end
    end

    initial begin
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                              input logic signed [SAMPLE_W-1:0] r);
        in_ch.valid        <= 1'b1;
        in_ch.left_sample  <= l;
        in_ch.right_sample <= r;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_frame('{left: l, right: r});
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [9:0] dly, input logic [15:0] gain,
                              input logic [30:0] step);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_DELAY;
        cfg_data  <= CFG_W'(dly);
        sb.set_reg(CFG_MAX_DELAY, CFG_W'(dly));
        @(posedge i_clk);
        cfg_index <= CFG_MIX_GAIN;
        cfg_data  <= CFG_W'(gain);
        sb.set_reg(CFG_MIX_GAIN, CFG_W'(gain));
        @(posedge i_clk);
        cfg_index <= CFG_PHASE_STEP;
        cfg_data  <= step;
        sb.set_reg(CFG_PHASE_STEP, step);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
            default: return w[SAMPLE_W-1:0];
        endcase
    endfunction

    task automatic random_settings();
        logic [9:0]  dly;
        logic [15:0] gain;
        logic [30:0] step;
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 3))
            0:       dly = 10'd0;
            1:       dly = 10'd1023;
            2:       dly = 10'($urandom_range(1, 40));
            default: dly = w[9:0];
        endcase
        w = $urandom();
        case ($urandom_range(0, 4))
            0:       gain = 16'd0;
            1:       gain = 16'd32768;
            2:       gain = 16'($urandom_range(32769, 65535));
            3:       gain = 16'($urandom_range(0, 32767));
            default: gain = w[15:0];
        endcase
        w = $urandom();
        case ($urandom_range(0, 3))
            0:       step = 31'd0;
            1:       step = 31'h7FFF_FFFF;
            2:       step = 31'($urandom_range(1, 1 << 24));
            default: step = w[30:0];
        endcase
        write_regs(dly, gain, step);
    endtask

    initial begin
        sb = new();
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.left_sample  <= '0;
        in_ch.right_sample <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_MAX_DELAY;
        cfg_data           <= '0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        hold_req     = 1'b0;
        quiet_cycles = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // early frames read unwritten history, as silence, at reset settings
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(-16'sd1, 16'sd0);
        send_frame(16'sd0, -16'sd1);
        send_frame(16'sh5555, 16'shAAAA);
        send_frame(16'shAAAA, 16'sh5555);
        drain_results();

        // zero delay, unity wet gain
        write_regs(10'd0, 16'd32768, 31'd0);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sd1, -16'sd1);
        send_frame(16'sd0, 16'sd0);
        drain_results();

        // wet gain beyond one, widest sweep, fastest phase
        write_regs(10'd1023, 16'hFFFF, 31'h7FFF_FFFF);
        send_frame(16'sh7FFF, 16'sh7FFF);
        send_frame(16'sh8000, 16'sh8000);
        send_frame(16'sh1234, -16'sh1234);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sd0, 16'sd0);
        drain_results();

        // dry only, shortest delay
        write_regs(10'd1, 16'd0, 31'h4000_0000);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(-16'sd1, 16'sd1);
        send_frame(16'sh4000, -16'sh4000);
        drain_results();

        for (int ph = 0; ph < 8; ph++) begin
            random_settings();
            src_idle_on  = (ph % 3 != 2) && (ph != 7);
            sink_idle_on = (ph % 3 != 1) && (ph != 7);
            if (ph == 1) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < 200; n++) begin
                if (ph == 3 && n == 100) begin
                    drain_results();
                end
                send_frame(rand_sample(), rand_sample());
            end
            drain_results();
        end

        if (sb.errors == 0) begin
            $display("tb_stereo_flanger passed");
        end else begin
            $display("tb_stereo_flanger failed");
        end
        $finish;
    end

endmodule
